// ===== design/fmp_pkg.sv =====
// Shared types, widths, register indexes and constant tables for the Moffat profile pipeline.
package fmp_pkg;

   // Fixed-point formats
   localparam int ONE_Q16    = 65536;
   localparam int LOG_INT_W  = 8;                 // signed integer part of a log2 result
   localparam int LOG_W      = LOG_INT_W + 16;    // signed Q16 log2 result
   localparam int EXP_IN_W   = 26;                // signed Q16 exp2 argument
   localparam int EXP_OUT_W  = 38;                // unsigned Q16 exp2 result
   localparam int DIV_NUM_W  = 29;                // numerator of log / p
   localparam int DIV_DEN_W  = 15;                // width of p

   // Configuration register indexes
   localparam logic [1:0] CSR_PEAK  = 2'd0;
   localparam logic [1:0] CSR_BETA  = 2'd1;
   localparam logic [1:0] CSR_POWER = 2'd2;
   localparam logic [1:0] CSR_FLAT  = 2'd3;

   // Side data carried with a beat through the radius part of the pipe
   typedef struct packed {
      logic [15:0] mx;
      logic        mx_zero;
      logic        mn_zero;
   } side_type;

   // 2^(2^-(k+1)) in Q30
   function automatic logic [30:0] pow2_frac(input logic [3:0] k);
      logic [30:0] v;
      unique case (k)
         4'd0:  v = 31'd1518500250;
         4'd1:  v = 31'd1276901417;
         4'd2:  v = 31'd1170923762;
         4'd3:  v = 31'd1121280436;
         4'd4:  v = 31'd1097253708;
         4'd5:  v = 31'd1085434106;
         4'd6:  v = 31'd1079572136;
         4'd7:  v = 31'd1076653033;
         4'd8:  v = 31'd1075196443;
         4'd9:  v = 31'd1074468888;
         4'd10: v = 31'd1074105294;
         4'd11: v = 31'd1073923544;
         4'd12: v = 31'd1073832680;
         4'd13: v = 31'd1073787251;
         4'd14: v = 31'd1073764537;
         4'd15: v = 31'd1073753181;
         default: v = 31'd1073741824;
      endcase
      return v;
   endfunction

endpackage

// ===== design/fmp_log2.sv =====
// Pipelined fixed-point log2: normalize, then sixteen squaring stages, signed Q16 result.
module fmp_log2 import fmp_pkg::*; #(
   parameter int LW = 16,
   parameter int FB = 8,
   parameter int SW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [LW-1:0]           in_data,
   input  logic [SW-1:0]           in_side,
   output logic                    out_valid,
   output logic signed [LOG_W-1:0] out_data,
   output logic [SW-1:0]           out_side
);

   localparam int AW    = (LW > 31) ? LW : 31;
   localparam int NW    = $clog2(AW);
   localparam int STEPS = 16;

   // Stage A: find the leading one
   logic [AW-1:0] v_ext;
   logic [NW-1:0] n_in;
   logic          a_valid_ff;
   logic [AW-1:0] a_v_ff;
   logic [NW-1:0] a_n_ff;
   logic [SW-1:0] a_side_ff;

   assign v_ext = AW'(in_data);

   always_comb begin
      n_in = '0;
      for (int i = 0; i < AW; i++) begin
         if (v_ext[i]) begin
            n_in = NW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_v_ff    <= v_ext;
         a_n_ff    <= n_in;
         a_side_ff <= in_side;
      end
   end

   // Stage B: align mantissa to Q30, integer part
   logic [AW-1:0]                aligned;
   logic                         valid_ff [0:STEPS];
   logic [30:0]                  m_ff     [0:STEPS];
   logic [15:0]                  frac_ff  [0:STEPS];
   logic signed [LOG_INT_W-1:0]  int_ff   [0:STEPS];
   logic [SW-1:0]                side_ff  [0:STEPS];

   assign aligned = a_v_ff << (NW'(AW - 1) - a_n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= aligned[AW-1 -: 31];
         frac_ff[0] <= '0;
         int_ff[0]  <= LOG_INT_W'(a_n_ff) - LOG_INT_W'(FB);
         side_ff[0] <= a_side_ff;
      end
   end

   // Squaring stages, one fraction bit each, most significant first
   for (genvar s = 0; s < STEPS; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      logic [30:0] m_in;
      logic [15:0] frac_in;

      assign sq = 62'(m_ff[s]) * 62'(m_ff[s]);
      assign t  = sq[61:30];

      always_comb begin
         frac_in = frac_ff[s];
         if (t[31]) begin
            m_in                   = t[31:1];
            frac_in[STEPS - 1 - s] = 1'b1;
         end else begin
            m_in = t[30:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[s+1]    <= m_in;
            frac_ff[s+1] <= frac_in;
            int_ff[s+1]  <= int_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_data  = {int_ff[STEPS], frac_ff[STEPS]};
   assign out_side  = side_ff[STEPS];

endmodule

// ===== design/fmp_exp2.sv =====
// Pipelined fixed-point exp2: sixteen table-product stages and a rounding shift, Q16 result.
module fmp_exp2 import fmp_pkg::*; #(
   parameter int EW = EXP_IN_W,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [EW-1:0] in_data,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [EXP_OUT_W-1:0] out_data,
   output logic [SW-1:0]        out_side
);

   localparam int STEPS = 16;
   localparam int IPW   = EW - 16;

   logic                  valid_ff [0:STEPS];
   logic signed [IPW-1:0] ip_ff    [0:STEPS];
   logic [15:0]           f_ff     [0:STEPS];
   logic [31:0]           acc_ff   [0:STEPS];
   logic [SW-1:0]         side_ff  [0:STEPS];

   // Stage A: split into floor integer part and fraction
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ip_ff[0]   <= in_data[EW-1:16];
         f_ff[0]    <= in_data[15:0];
         acc_ff[0]  <= 32'h4000_0000;
         side_ff[0] <= in_side;
      end
   end

   // Product stages, one fraction bit each
   for (genvar s = 0; s < STEPS; s++) begin : g_mul
      logic [63:0] prod;
      logic [31:0] acc_in;

      assign prod   = 64'(acc_ff[s]) * 64'(pow2_frac(4'(s))) + 64'h2000_0000;
      assign acc_in = f_ff[s][STEPS - 1 - s] ? prod[61:30] : acc_ff[s];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ip_ff[s+1]   <= ip_ff[s];
            f_ff[s+1]    <= f_ff[s];
            acc_ff[s+1]  <= acc_in;
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // Final stage: scale by the integer part with rounding
   logic                 out_valid_ff;
   logic [EXP_OUT_W-1:0] out_data_ff;
   logic [EXP_OUT_W-1:0] out_data_in;
   logic [SW-1:0]        out_side_ff;

   always_comb begin
      int          ipi;
      int          sh;
      logic [63:0] acc_w;
      logic [63:0] res;
      ipi   = int'(ip_ff[STEPS]);
      acc_w = 64'(acc_ff[STEPS]);
      res   = '0;
      sh    = 0;
      if (ipi >= -40) begin
         if (ipi > 20) begin
            ipi = 20;
         end
         sh = 14 - ipi;
         if (sh <= 0) begin
            res = acc_w << (6'(-sh));
         end else begin
            res = (acc_w + (64'd1 << (6'(sh - 1)))) >> (6'(sh));
         end
      end
      out_data_in = res[EXP_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
         out_side_ff <= side_ff[STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_side  = out_side_ff;

endmodule

// ===== design/fmp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; hold the divisor steady.
module fmp_div import fmp_pkg::*; #(
   parameter int NW = DIV_NUM_W,
   parameter int DW = DIV_DEN_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [0:NW-1];
   logic [NW-1:0] num_ff   [0:NW-1];
   logic [NW-1:0] quo_ff   [0:NW-1];
   logic [DW-1:0] rem_ff   [0:NW-1];
   logic [SW-1:0] side_ff  [0:NW-1];

   for (genvar s = 0; s < NW; s++) begin : g_div
      logic          src_valid;
      logic [NW-1:0] src_num;
      logic [NW-1:0] src_quo;
      logic [DW-1:0] src_rem;
      logic [SW-1:0] src_side;
      logic [DW:0]   r2;
      logic [DW:0]   diff;
      logic          ge;
      logic [NW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = in_num;
         assign src_quo   = '0;
         assign src_rem   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
         assign src_num   = num_ff[s-1];
         assign src_quo   = quo_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_side  = side_ff[s-1];
      end

      // Shift in the next numerator bit and try the subtraction
      assign r2   = {src_rem, src_num[NW - 1 - s]};
      assign diff = r2 - {1'b0, in_den};
      assign ge   = (r2 >= {1'b0, in_den});

      always_comb begin
         quo_in                = src_quo;
         quo_in[NW - 1 - s]    = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s]  <= src_num;
            quo_ff[s]  <= quo_in;
            rem_ff[s]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

// ===== design/flattened_moffat_profile.sv =====
// Top level of the flattened Moffat profile pipeline.
// Takes one (x, y) pixel offset per cycle while the pipe is not held and returns one
// saturated intensity per beat, in order. A beat passes through three log2 units in
// series (the min and max logs run side by side) and three exp2 units, 18 stages each,
// the 29-stage divider that forms log / p, and thirteen single-stage registers between
// them. The whole pipe advances together and holds when a result is waiting and
// rsp_tready is low. Configuration is sampled live, so the user must write registers
// only while no beat is in flight; the block itself does not enforce this.
module flattened_moffat_profile import fmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_offset, [31:16] y_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] profile_value
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SIDE_W = $bits(side_type);

   // Configuration registers
   logic [15:0] peak_ff;
   logic [14:0] beta_ff;
   logic [14:0] power_ff;
   logic [14:0] flat_ff;
   logic [14:0] p_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= 16'd65535;
         beta_ff  <= 15'd4096;
         power_ff <= 15'd8192;
         flat_ff  <= 15'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PEAK:  peak_ff  <= csr_wdata;
            CSR_BETA:  beta_ff  <= csr_wdata[14:0];
            CSR_POWER: power_ff <= csr_wdata[14:0];
            CSR_FLAT:  flat_ff  <= csr_wdata[14:0];
            default:   peak_ff  <= peak_ff;
         endcase
      end
   end

   assign p_eff = (power_ff < 15'd1024) ? 15'd1024 : power_ff;

   // Global advance
   logic en;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: magnitudes, max and min
   logic [15:0] x_in;
   logic [15:0] y_in;
   logic [15:0] ax;
   logic [15:0] ay;
   logic        s1_valid_ff;
   logic [15:0] mx_ff;
   logic [15:0] mn_ff;

   assign x_in = req_tdata[15:0];
   assign y_in = req_tdata[31:16];
   assign ax   = x_in[15] ? (16'd0 - x_in) : x_in;
   assign ay   = y_in[15] ? (16'd0 - y_in) : y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= (ax > ay) ? ax : ay;
         mn_ff <= (ax > ay) ? ay : ax;
      end
   end

   // log2 of min and max, Q8.8 inputs
   logic                    la_valid;
   logic signed [LOG_W-1:0] la_data;
   logic [1:0]              la_side;
   logic                    lb_valid;
   logic signed [LOG_W-1:0] lb_data;
   logic [15:0]             lb_side;

   fmp_log2 #(.LW(16), .FB(8), .SW(2)) u_log_mn (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s1_valid_ff), .in_data(mn_ff),
      .in_side({mx_ff == 16'd0, mn_ff == 16'd0}),
      .out_valid(la_valid), .out_data(la_data), .out_side(la_side)
   );

   fmp_log2 #(.LW(16), .FB(8), .SW(16)) u_log_mx (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s1_valid_ff), .in_data(mx_ff), .in_side(mx_ff),
      .out_valid(lb_valid), .out_data(lb_data), .out_side(lb_side)
   );

   // Stage 2: log ratio
   side_type                s2_side;
   logic                    s2_valid_ff;
   logic signed [LOG_W-1:0] lt_ff;
   side_type                s2_side_ff;

   assign s2_side = '{mx: lb_side, mx_zero: la_side[1], mn_zero: la_side[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= la_valid && lb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lt_ff      <= la_data - lb_data;
         s2_side_ff <= s2_side;
      end
   end

   // Stage 3: times p
   logic                       s3_valid_ff;
   logic signed [LOG_W+15:0]   ltp_ff;
   side_type                   s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ltp_ff     <= (LOG_W+16)'(lt_ff) * (LOG_W+16)'(signed'({1'b0, p_eff}));
         s3_side_ff <= s2_side_ff;
      end
   end

   // Stage 4: divide by 4096 toward zero
   logic [LOG_W+15:0]          ltp_mag;
   logic [LOG_W+15:0]          ltp_shr;
   logic                       s4_valid_ff;
   logic signed [EXP_IN_W-1:0] e1_ff;
   side_type                   s4_side_ff;

   assign ltp_mag = ltp_ff[LOG_W+15] ? ((LOG_W+16)'(0) - ltp_ff) : ltp_ff;
   assign ltp_shr = ltp_mag >> 12;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff      <= ltp_ff[LOG_W+15] ? (EXP_IN_W'(0) - ltp_shr[EXP_IN_W-1:0])
                                        : ltp_shr[EXP_IN_W-1:0];
         s4_side_ff <= s3_side_ff;
      end
   end

   // q = (min/max)^p
   logic                 q_valid;
   logic [EXP_OUT_W-1:0] q_data;
   logic [SIDE_W-1:0]    q_side;

   fmp_exp2 #(.EW(EXP_IN_W), .SW(SIDE_W)) u_exp_q (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s4_valid_ff), .in_data(e1_ff), .in_side(s4_side_ff),
      .out_valid(q_valid), .out_data(q_data), .out_side(q_side)
   );

   // Stage 5: 1 + q
   logic              s5_valid_ff;
   logic [17:0]       v_ff;
   logic [SIDE_W-1:0] s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff       <= 18'(ONE_Q16) + 18'(q_data[16:0]);
         s5_side_ff <= q_side;
      end
   end

   // log2(1 + q), Q16 input
   logic                    ls_valid;
   logic signed [LOG_W-1:0] ls_data;
   logic [SIDE_W-1:0]       ls_side;

   fmp_log2 #(.LW(18), .FB(16), .SW(SIDE_W)) u_log_s (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s5_valid_ff), .in_data(v_ff), .in_side(s5_side_ff),
      .out_valid(ls_valid), .out_data(ls_data), .out_side(ls_side)
   );

   // log / p
   logic                 dv_valid;
   logic [DIV_NUM_W-1:0] dv_quo;
   logic [SIDE_W-1:0]    dv_side;

   fmp_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .SW(SIDE_W)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(ls_valid), .in_num({ls_data[16:0], 12'd0}), .in_den(p_eff),
      .in_side(ls_side),
      .out_valid(dv_valid), .out_quo(dv_quo), .out_side(dv_side)
   );

   // g = (1 + q)^(1/p)
   logic                 g_valid;
   logic [EXP_OUT_W-1:0] g_data;
   logic [SIDE_W-1:0]    g_side;

   fmp_exp2 #(.EW(EXP_IN_W), .SW(SIDE_W)) u_exp_g (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(dv_valid), .in_data(signed'({1'b0, dv_quo[EXP_IN_W-2:0]})),
      .in_side(dv_side),
      .out_valid(g_valid), .out_data(g_data), .out_side(g_side)
   );

   // Stage 7: max * g
   side_type    g_side_s;
   logic        s7_valid_ff;
   logic [37:0] mg_ff;
   side_type    s7_side_ff;

   assign g_side_s = g_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= g_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mg_ff      <= 38'(g_side_s.mx) * 38'(g_data[21:0]);
         s7_side_ff <= g_side_s;
      end
   end

   // Stage 8: round radius, handle zero axes
   logic [37:0] mg_rnd;
   logic        s8_valid_ff;
   logic [21:0] r_ff;

   assign mg_rnd = mg_ff + 38'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (s7_side_ff.mx_zero) begin
            r_ff <= '0;
         end else if (s7_side_ff.mn_zero) begin
            r_ff <= 22'(s7_side_ff.mx);
         end else begin
            r_ff <= mg_rnd[37:16];
         end
      end
   end

   // Stage 9: subtract flat radius
   logic signed [22:0] z;
   logic               s9_valid_ff;
   logic               zneg9_ff;
   logic [20:0]        zu_ff;

   assign z = signed'({1'b0, r_ff}) - signed'({8'd0, flat_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (en) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zneg9_ff <= z[22];
         zu_ff    <= z[20:0];
      end
   end

   // Stage 10: z squared
   logic        s10_valid_ff;
   logic        zneg10_ff;
   logic [41:0] zsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (en) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zsq_ff    <= 42'(zu_ff) * 42'(zu_ff);
         zneg10_ff <= zneg9_ff;
      end
   end

   // Stage 11: 1 + z^2
   logic        s11_valid_ff;
   logic        zneg11_ff;
   logic [41:0] w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (en) begin
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff      <= zsq_ff + 42'(ONE_Q16);
         zneg11_ff <= zneg10_ff;
      end
   end

   // log2(1 + z^2)
   logic                    lw_valid;
   logic signed [LOG_W-1:0] lw_data;
   logic                    lw_side;

   fmp_log2 #(.LW(42), .FB(16), .SW(1)) u_log_w (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s11_valid_ff), .in_data(w_ff), .in_side(zneg11_ff),
      .out_valid(lw_valid), .out_data(lw_data), .out_side(lw_side)
   );

   // Stage 12: times beta
   logic        s12_valid_ff;
   logic        zneg12_ff;
   logic [35:0] lwb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
      end else if (en) begin
         s12_valid_ff <= lw_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lwb_ff    <= 36'(lw_data[20:0]) * 36'(beta_ff);
         zneg12_ff <= lw_side;
      end
   end

   // Stage 13: negated exponent
   logic                       s13_valid_ff;
   logic                       zneg13_ff;
   logic signed [EXP_IN_W-1:0] e3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_valid_ff <= 1'b0;
      end else if (en) begin
         s13_valid_ff <= s12_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e3_ff     <= EXP_IN_W'(0) - EXP_IN_W'(lwb_ff[35:12]);
         zneg13_ff <= zneg12_ff;
      end
   end

   // f = (1 + z^2)^(-beta)
   logic                 f_valid;
   logic [EXP_OUT_W-1:0] f_data;
   logic                 f_side;

   fmp_exp2 #(.EW(EXP_IN_W), .SW(1)) u_exp_f (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s13_valid_ff), .in_data(e3_ff), .in_side(zneg13_ff),
      .out_valid(f_valid), .out_data(f_data), .out_side(f_side)
   );

   // Output register: scale by peak, round, saturate
   logic [32:0] pf;
   logic [15:0] res_in;
   logic [15:0] rsp_data_ff;

   assign pf = 33'(peak_ff) * 33'(f_data[16:0]) + 33'd32768;

   always_comb begin
      if (f_side) begin
         res_in = peak_ff;
      end else if (pf[32]) begin
         res_in = 16'hFFFF;
      end else begin
         res_in = pf[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
